// ===== design/mvps_pkg.sv =====
// Shared types and constants for the maximal violating pair selector.
// No dependencies; imported by every module of the block.
package mvps_pkg;

    // Index and tolerance widths fixed by the port definition
    localparam int IDX_W = 16;
    localparam int TOL_W = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    // Class label codes carried on class_negative
    localparam logic CLASS_POS = 1'b0;
    localparam logic CLASS_NEG = 1'b1;

    // Found flags and extreme indices of one class at the end of a scan
    typedef struct packed {
        logic             min_found;
        logic             max_found;
        logic [IDX_W-1:0] min_index;
        logic [IDX_W-1:0] max_index;
    } class_ext_t;

endpackage

// ===== design/mvps_track.sv =====
// Per-class extreme tracker: running min over elements not at the upper bound,
// running max over elements not at the lower bound, with a snapshot on the last item.
// Depends on mvps_pkg.
module mvps_track
    import mvps_pkg::*;
#(
    parameter int GW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 hit,
    input  logic                 last,
    input  logic                 at_upper_bound,
    input  logic                 at_lower_bound,
    input  logic signed [GW-1:0] gradient,
    input  logic [IDX_W-1:0]     index,
    output logic signed [GW-1:0] snap_min_value,
    output logic signed [GW-1:0] snap_max_value,
    output class_ext_t           snap_ext
);

    logic signed [GW-1:0] min_value_reg;
    logic signed [GW-1:0] min_value_next;
    logic signed [GW-1:0] max_value_reg;
    logic signed [GW-1:0] max_value_next;
    logic [IDX_W-1:0]     min_index_reg;
    logic [IDX_W-1:0]     min_index_next;
    logic [IDX_W-1:0]     max_index_reg;
    logic [IDX_W-1:0]     max_index_next;
    logic                 min_found_reg;
    logic                 min_found_next;
    logic                 max_found_reg;
    logic                 max_found_next;
    logic signed [GW-1:0] snap_min_value_reg;
    logic signed [GW-1:0] snap_max_value_reg;
    logic                 snap_min_found_reg;
    logic                 snap_max_found_reg;
    logic [IDX_W-1:0]     snap_min_index_reg;
    logic [IDX_W-1:0]     snap_max_index_reg;
    logic                 min_take;
    logic                 max_take;

    // Strict compares keep the earlier element on ties
    always_comb
    begin
        min_take = hit && !at_upper_bound && (!min_found_reg || (gradient < min_value_reg));
        max_take = hit && !at_lower_bound && (!max_found_reg || (gradient > max_value_reg));
        min_value_next = min_take ? gradient : min_value_reg;
        min_index_next = min_take ? index : min_index_reg;
        min_found_next = min_found_reg || min_take;
        max_value_next = max_take ? gradient : max_value_reg;
        max_index_next = max_take ? index : max_index_reg;
        max_found_next = max_found_reg || max_take;
    end

    // Advance live trackers; clear them once the last item is folded in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_found_reg <= 1'b0;
            max_found_reg <= 1'b0;
        end
        else if (step)
        begin
            min_found_reg <= last ? 1'b0 : min_found_next;
            max_found_reg <= last ? 1'b0 : max_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            min_value_reg <= min_value_next;
            min_index_reg <= min_index_next;
            max_value_reg <= max_value_next;
            max_index_reg <= max_index_next;
        end
    end

    // Capture the final extremes of the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_min_found_reg <= 1'b0;
            snap_max_found_reg <= 1'b0;
        end
        else if (step && last)
        begin
            snap_min_found_reg <= min_found_next;
            snap_max_found_reg <= max_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last)
        begin
            snap_min_value_reg <= min_value_next;
            snap_max_value_reg <= max_value_next;
            snap_min_index_reg <= min_index_next;
            snap_max_index_reg <= max_index_next;
        end
    end

    assign snap_min_value = snap_min_value_reg;
    assign snap_max_value = snap_max_value_reg;
    assign snap_ext       = {snap_min_found_reg, snap_max_found_reg,
                             snap_min_index_reg, snap_max_index_reg};

endmodule

// ===== design/mvps_select.sv =====
// Gap and decision stages: class gaps, tolerance test, pair choice, result register.
// Depends on mvps_pkg.
module mvps_select
    import mvps_pkg::*;
#(
    parameter int GW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 snap_valid,
    input  logic signed [GW-1:0] pos_min_value,
    input  logic signed [GW-1:0] pos_max_value,
    input  class_ext_t           pos_ext,
    input  logic signed [GW-1:0] neg_min_value,
    input  logic signed [GW-1:0] neg_max_value,
    input  class_ext_t           neg_ext,
    input  logic [TOL_W-1:0]     tolerance,
    output logic                 out_valid,
    output logic                 optimal,
    output logic [IDX_W-1:0]     first_index,
    output logic [IDX_W-1:0]     second_index
);

    localparam int DW = GW + 1;
    localparam int CW = (DW > TOL_W + 1) ? DW : TOL_W + 1;

    logic                 gap_valid_reg;
    logic signed [DW-1:0] gap1_reg;
    logic signed [DW-1:0] gap2_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    class_ext_t           pos_ext_reg;
    class_ext_t           neg_ext_reg;
    logic signed [CW-1:0] gap1_ext;
    logic signed [CW-1:0] gap2_ext;
    logic signed [CW-1:0] tol_ext;
    logic                 lt1;
    logic                 lt2;
    logic                 one_wins;
    logic                 opt;
    logic                 pick_one;
    logic                 out_valid_reg;
    logic                 optimal_reg;
    logic [IDX_W-1:0]     first_index_reg;
    logic [IDX_W-1:0]     second_index_reg;

    // Form the class gaps at full width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_valid_reg <= 1'b0;
        else if (advance)
            gap_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && snap_valid)
        begin
            gap1_reg    <= DW'(pos_max_value) - DW'(pos_min_value);
            gap2_reg    <= DW'(neg_max_value) - DW'(neg_min_value);
            v1_reg      <= pos_ext.min_found && pos_ext.max_found;
            v2_reg      <= neg_ext.min_found && neg_ext.max_found;
            pos_ext_reg <= pos_ext;
            neg_ext_reg <= neg_ext;
        end
    end

    // Test against tolerance and choose the class; a missing class counts as -inf
    always_comb
    begin
        gap1_ext = CW'(gap1_reg);
        gap2_ext = CW'(gap2_reg);
        tol_ext  = $signed({{(CW - TOL_W){1'b0}}, tolerance});
        lt1      = gap1_ext < tol_ext;
        lt2      = gap2_ext < tol_ext;
        one_wins = gap1_ext > gap2_ext;
        priority if (!v1_reg && !v2_reg)
            opt = 1'b1;
        else if (v1_reg && v2_reg)
            opt = one_wins ? lt1 : lt2;
        else
            opt = v1_reg ? lt1 : lt2;
        pick_one = (v1_reg && v2_reg) ? one_wins : v1_reg;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= gap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && gap_valid_reg)
        begin
            optimal_reg <= opt;
            priority if (opt)
            begin
                first_index_reg  <= '0;
                second_index_reg <= '0;
            end
            else if (pick_one)
            begin
                first_index_reg  <= pos_ext_reg.max_index;
                second_index_reg <= pos_ext_reg.min_index;
            end
            else
            begin
                first_index_reg  <= neg_ext_reg.max_index;
                second_index_reg <= neg_ext_reg.min_index;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign optimal      = optimal_reg;
    assign first_index  = first_index_reg;
    assign second_index = second_index_reg;

endmodule

// ===== design/max_violating_pair_select.sv =====
// Maximal violating pair selector: one element accepted per cycle while no result is stalled, four register stages.
// Result path: the last element passes the tracker snapshot, gap and result registers before out_valid.
// Throughput: 1 element per cycle; the whole pipeline holds only while a result is stalled.
// Reset: asynchronous active low; clears counter, found flags and valids, tolerance to 66.
// Depends on mvps_pkg, mvps_track and mvps_select.
module max_violating_pair_select
    import mvps_pkg::*;
#(
    parameter int MAX_ELEMENTS  = 65536,
    parameter int GRADIENT_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOL_W-1:0]   tolerance,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               class_negative,
    input  logic               at_upper_bound,
    input  logic               at_lower_bound,
    input  logic signed [31:0] gradient,
    input  logic               last_element,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               optimal,
    output logic [IDX_W-1:0]   first_index,
    output logic [IDX_W-1:0]   second_index
);

    localparam int GW    = GRADIENT_BITS;
    localparam int CNT_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;

    logic                 advance;
    logic [TOL_W-1:0]     tolerance_reg;
    logic                 in_valid_reg;
    logic                 class_negative_reg;
    logic                 at_upper_bound_reg;
    logic                 at_lower_bound_reg;
    logic [31:0]          gradient_reg;
    logic                 last_element_reg;
    logic signed [GW-1:0] grad_s;
    logic [CNT_W-1:0]     counter_reg;
    logic [CNT_W-1:0]     counter_next;
    logic [IDX_W-1:0]     index;
    logic                 step;
    logic                 snap_valid_reg;
    logic signed [GW-1:0] pos_min_value;
    logic signed [GW-1:0] pos_max_value;
    logic signed [GW-1:0] neg_min_value;
    logic signed [GW-1:0] neg_max_value;
    class_ext_t           pos_ext;
    class_ext_t           neg_ext;

    // Hold every pipeline stage while a finished result waits on the output
    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;
    assign step      = advance && in_valid_reg;

    // Tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= TOL_RESET;
        else if (cfg_valid)
            tolerance_reg <= tolerance;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            class_negative_reg <= class_negative;
            at_upper_bound_reg <= at_upper_bound;
            at_lower_bound_reg <= at_lower_bound;
            gradient_reg       <= gradient;
            last_element_reg   <= last_element;
        end
    end

    // Take the low gradient bits signed, or sign-extend when wider than the port
    generate
        if (GW <= 32)
        begin : g_grad_narrow
            assign grad_s = $signed(gradient_reg[GW-1:0]);
        end
        else
        begin : g_grad_wide
            assign grad_s = $signed({{(GW - 32){gradient_reg[31]}}, gradient_reg});
        end
    endgenerate

    // Element counter: wrap at the element limit, restart after the last item
    always_comb
    begin
        if (last_element_reg || (counter_reg == CNT_W'(MAX_ELEMENTS - 1)))
            counter_next = '0;
        else
            counter_next = counter_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counter_reg <= '0;
        else if (step)
            counter_reg <= counter_next;
    end

    generate
        if (CNT_W >= IDX_W)
        begin : g_idx_trunc
            assign index = counter_reg[IDX_W-1:0];
        end
        else
        begin : g_idx_ext
            assign index = {{(IDX_W - CNT_W){1'b0}}, counter_reg};
        end
    endgenerate

    // Flag a completed scan for the gap stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (advance)
            snap_valid_reg <= in_valid_reg && last_element_reg;
    end

    mvps_track #(
        .GW(GW)
    ) u_track_pos (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .hit            (class_negative_reg == CLASS_POS),
        .last           (last_element_reg),
        .at_upper_bound (at_upper_bound_reg),
        .at_lower_bound (at_lower_bound_reg),
        .gradient       (grad_s),
        .index          (index),
        .snap_min_value (pos_min_value),
        .snap_max_value (pos_max_value),
        .snap_ext       (pos_ext)
    );

    mvps_track #(
        .GW(GW)
    ) u_track_neg (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .hit            (class_negative_reg == CLASS_NEG),
        .last           (last_element_reg),
        .at_upper_bound (at_upper_bound_reg),
        .at_lower_bound (at_lower_bound_reg),
        .gradient       (grad_s),
        .index          (index),
        .snap_min_value (neg_min_value),
        .snap_max_value (neg_max_value),
        .snap_ext       (neg_ext)
    );

    mvps_select #(
        .GW(GW)
    ) u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .snap_valid    (snap_valid_reg),
        .pos_min_value (pos_min_value),
        .pos_max_value (pos_max_value),
        .pos_ext       (pos_ext),
        .neg_min_value (neg_min_value),
        .neg_max_value (neg_max_value),
        .neg_ext       (neg_ext),
        .tolerance     (tolerance_reg),
        .out_valid     (out_valid),
        .optimal       (optimal),
        .first_index   (first_index),
        .second_index  (second_index)
    );

endmodule

// ===== tb/sv/max_violating_pair_select_test.sv =====
// Self-checking testbench for max_violating_pair_select: per-class min/max gradient
// tracking, pair selection and the tolerance register, checked against a local predictor.
// Depends on mvps_pkg and the max_violating_pair_select RTL.
module max_violating_pair_select_test;
    import mvps_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PRESSURE_CYCLES = 400;
    localparam int PHASE_ITEMS     = 400;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [31:0] GRAD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] GRAD_MIN = 32'h8000_0000;
    localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

    typedef struct packed {
        logic        cls;
        logic        ub;
        logic        lb;
        logic [31:0] grad;
        logic        last;
    } element_t;

    typedef struct packed {
        logic             optimal;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
    } selection_t;

    typedef struct {
        element_t   elem;
        bit         pinned;
        selection_t sel;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TOL_W-1:0]   tolerance;
    logic               in_valid;
    logic               in_stall;
    logic               class_negative;
    logic               at_upper_bound;
    logic               at_lower_bound;
    logic signed [31:0] gradient;
    logic               last_element;
    logic               out_valid;
    logic               out_stall;
    logic               optimal;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;

    // Predictor state: per-class extremes, found bits and the element counter
    logic signed [31:0] min_grad [2];
    logic signed [31:0] max_grad [2];
    logic [IDX_W-1:0]   min_idx [2];
    logic [IDX_W-1:0]   max_idx [2];
    logic [1:0]         min_seen = '0;
    logic [1:0]         max_seen = '0;
    logic [IDX_W-1:0]   elem_count = '0;
    logic [TOL_W-1:0]   tol_reg = TOL_RESET;

    selection_t pending_selections[$];
    stim_row_t  directed[$];
    bit         pin_on = 1'b0;
    selection_t pin_sel = '0;
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         pressure_pending = 1'b0;
    int         hold_left = 0;

    max_violating_pair_select dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .tolerance      (tolerance),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .class_negative (class_negative),
        .at_upper_bound (at_upper_bound),
        .at_lower_bound (at_lower_bound),
        .gradient       (gradient),
        .last_element   (last_element),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .optimal        (optimal),
        .first_index    (first_index),
        .second_index   (second_index)
    );

    always #CLK_HALF clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Fold one element into the trackers; on a last element form the selection and clear
    task automatic track_element(input element_t e, output logic emits, output selection_t sel);
        logic signed [32:0] gap_pos;
        logic signed [32:0] gap_neg;
        logic signed [32:0] gap_top;
        logic signed [32:0] tol_s;
        logic               ok_pos;
        logic               ok_neg;
        logic               pick_pos;
        if (!e.ub && (!min_seen[e.cls] || $signed(e.grad) < min_grad[e.cls]))
        begin
            min_grad[e.cls] = e.grad;
            min_idx[e.cls]  = elem_count;
            min_seen[e.cls] = 1'b1;
        end
        if (!e.lb && (!max_seen[e.cls] || $signed(e.grad) > max_grad[e.cls]))
        begin
            max_grad[e.cls] = e.grad;
            max_idx[e.cls]  = elem_count;
            max_seen[e.cls] = 1'b1;
        end
        // 16-bit counter wraps at the element limit
        elem_count = elem_count + 1'b1;
        emits = e.last;
        sel   = '0;
        if (e.last)
        begin
            ok_pos  = min_seen[CLASS_POS] && max_seen[CLASS_POS];
            ok_neg  = min_seen[CLASS_NEG] && max_seen[CLASS_NEG];
            gap_pos = {max_grad[CLASS_POS][31], max_grad[CLASS_POS]}
                    - {min_grad[CLASS_POS][31], min_grad[CLASS_POS]};
            gap_neg = {max_grad[CLASS_NEG][31], max_grad[CLASS_NEG]}
                    - {min_grad[CLASS_NEG][31], min_grad[CLASS_NEG]};
            tol_s   = {2'b00, tol_reg};
            if (ok_pos && ok_neg)
            begin
                pick_pos = gap_pos > gap_neg;
                gap_top  = pick_pos ? gap_pos : gap_neg;
            end
            else
            begin
                pick_pos = ok_pos;
                gap_top  = ok_pos ? gap_pos : gap_neg;
            end
            // A class missing an extreme counts as minus infinity
            sel.optimal = !(ok_pos || ok_neg) || (gap_top < tol_s);
            if (!sel.optimal)
            begin
                sel.first  = pick_pos ? max_idx[CLASS_POS] : max_idx[CLASS_NEG];
                sel.second = pick_pos ? min_idx[CLASS_POS] : min_idx[CLASS_NEG];
            end
            min_seen   = '0;
            max_seen   = '0;
            elem_count = '0;
        end
    endtask

    // Predict on every accepted item
    always @(posedge clk)
    begin : element_capture
        element_t   e;
        logic       emits;
        selection_t sel;
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
        begin
            e = {class_negative, at_upper_bound, at_lower_bound, gradient, last_element};
            track_element(e, emits, sel);
            if (emits)
                pending_selections.push_back(pin_on ? pin_sel : sel);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        selection_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_selections.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected selection: optimal=%0b first=%0d second=%0d",
                             optimal, first_index, second_index);
            end
            else
            begin
                want = pending_selections.pop_front();
                if (optimal !== want.optimal || first_index !== want.first
                    || second_index !== want.second)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $write("selection mismatch: expected optimal=%0b first=%0d second=%0d,",
                               want.optimal, want.first, want.second);
                        $display(" got optimal=%0b first=%0d second=%0d",
                                 optimal, first_index, second_index);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (pressure_pending)
        begin
            hold_left        = PRESSURE_CYCLES;
            pressure_pending = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic stim_row_t make_row(input logic cls, input logic ub, input logic lb,
                                           input logic [31:0] grad, input logic last,
                                           input bit pinned, input logic opt,
                                           input logic [IDX_W-1:0] first,
                                           input logic [IDX_W-1:0] second);
        stim_row_t r;
        r.elem   = {cls, ub, lb, grad, last};
        r.pinned = pinned;
        r.sel    = {opt, first, second};
        return r;
    endfunction

    function automatic logic [31:0] random_gradient();
        logic [31:0] g;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(3))
                    0:       g = GRAD_MAX;
                    1:       g = GRAD_MIN;
                    2:       g = 32'h0;
                    default: g = 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: g = 32'($urandom_range(4095)) - 32'd2048;
            4, 5:    g = 32'($urandom_range(1 << 21)) - 32'd1048576;
            default: g = $urandom;
        endcase
        return g;
    endfunction

    // Present one item at a falling edge and hold it until accepted
    task automatic offer(input element_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        class_negative <= e.cls;
        at_upper_bound <= e.ub;
        at_lower_bound <= e.lb;
        gradient       <= e.grad;
        last_element   <= e.last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One scan of random elements ending in a last element
    task automatic random_scan();
        int       len;
        element_t e;
        len = ($urandom_range(7) == 0) ? $urandom_range(64, 11) : $urandom_range(10, 1);
        for (int k = 0; k < len; k++)
        begin
            e.cls  = 1'($urandom_range(1));
            e.ub   = ($urandom_range(3) == 0);
            e.lb   = ($urandom_range(3) == 0);
            e.grad = random_gradient();
            e.last = (k == len - 1);
            offer(e);
            items_sent++;
        end
    endtask

    // Drop valid, wait for every expected selection, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_selections.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_valid <= 1'b1;
        tolerance <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        tol_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        items_sent = 0;
        while (items_sent < PHASE_ITEMS)
            random_scan();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        tolerance      = TOL_RESET;
        in_valid       = 1'b0;
        class_negative = CLASS_POS;
        at_upper_bound = 1'b0;
        at_lower_bound = 1'b0;
        gradient       = '0;
        last_element   = 1'b0;
        out_stall      = 1'b0;

        // Directed scans under the reset tolerance
        // lone element: zero gap is below tolerance
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd0, 1, 1, 1, 0, 0));
        // element at both bounds joins nothing: both classes missing
        directed.push_back(make_row(CLASS_NEG, 1, 1, GRAD_MAX, 1, 1, 1, 0, 0));
        // full-range gap in class one, each extreme on one side only
        directed.push_back(make_row(CLASS_POS, 1, 0, GRAD_MAX, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_POS, 0, 1, GRAD_MIN, 1, 1, 0, 0, 1));
        // same in class two
        directed.push_back(make_row(CLASS_NEG, 0, 1, GRAD_MIN, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 1, 0, GRAD_MAX, 1, 1, 0, 1, 0));
        // equal gaps go to class two
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd100, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd300, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 0, 0, -32'sd100, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 0, 0, 32'd100, 1, 1, 0, 3, 2));
        // ties keep the earlier element
        directed.push_back(make_row(CLASS_NEG, 0, 0, -32'sd500, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 0, 0, -32'sd500, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 0, 0, 32'd500, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 0, 0, 32'd500, 1, 1, 0, 2, 0));
        // class two lacks a minimum, class one's zero gap decides
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd10000, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 1, 0, -32'sd10000, 1, 1, 1, 0, 0));
        // gap equal to tolerance is not optimal, one below is
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd66, 1, 1, 0, 1, 0));
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_POS, 0, 0, 32'd65, 1, 1, 1, 0, 0));
        // maximum below minimum gives a negative gap
        directed.push_back(make_row(CLASS_NEG, 0, 1, 32'd500, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CLASS_NEG, 1, 0, -32'sd500, 1, 0, 0, 0, 0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            pin_on  = directed[i].pinned;
            pin_sel = directed[i].sel;
            offer(directed[i].elem);
        end
        pin_on = 1'b0;

        // Zero tolerance, no idling
        settle();
        write_tolerance('0);
        random_phase();

        // Largest tolerance, sender mostly idle
        settle();
        write_tolerance(TOL_MAX);
        send_idle_pct = 88;
        random_phase();

        // Small tolerance, receiver mostly stalled, with one long hold-off
        settle();
        write_tolerance(TOL_W'($urandom_range(4095)));
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        @(posedge clk);
        pressure_pending = 1'b1;
        @(negedge clk);
        random_phase();

        // Medium tolerance, light idling on both sides
        settle();
        write_tolerance(TOL_W'($urandom_range(1 << 24)));
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        random_phase();

        settle();
        if (mismatch_count == 0 && pending_selections.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/mvps_pkg.sv
design/mvps_track.sv
design/mvps_select.sv
design/max_violating_pair_select.sv
tb/sv/max_violating_pair_select_test.sv
